// File: sv/iad_pkg.sv
package iad_pkg;

   typedef enum logic [4:0] {
      OP_LT = 5'd0, OP_ODD = 5'd1, OP_EVEN = 5'd2, OP_ZERO = 5'd3, OP_POS = 5'd4,
      OP_NEG = 5'd5, OP_ABS = 5'd6, OP_NEGATE = 5'd7, OP_ADD = 5'd8, OP_SUB = 5'd9,
      OP_MUL = 5'd10, OP_QUOT = 5'd11, OP_REM = 5'd12, OP_MOD = 5'd13,
      OP_TRUNCDIV = 5'd14, OP_ASH = 5'd15, OP_NOT = 5'd16, OP_AND = 5'd17,
      OP_OR = 5'd18, OP_XOR = 5'd19
   } op_type;

   localparam int OP_WIDTH = 5;

endpackage

// File: sv/iad_cell.sv
module iad_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int BIT_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic                  in_div,
   input  logic [4:0]            in_op,
   input  logic [DATA_WIDTH-1:0] in_a,
   input  logic [DATA_WIDTH-1:0] in_b,
   input  logic                  in_na,
   input  logic                  in_nb,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_quo,
   input  logic [DATA_WIDTH-1:0] in_dvd,
   input  logic [DATA_WIDTH-1:0] in_dvs,
   output logic                  out_valid,
   output logic                  out_div,
   output logic [4:0]            out_op,
   output logic [DATA_WIDTH-1:0] out_a,
   output logic [DATA_WIDTH-1:0] out_b,
   output logic                  out_na,
   output logic                  out_nb,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_quo,
   output logic [DATA_WIDTH-1:0] out_dvd,
   output logic [DATA_WIDTH-1:0] out_dvs
);
   logic                  valid_ff;
   logic                  div_ff;
   logic [4:0]            op_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff, rem_ff, quo_ff, dvd_ff, dvs_ff;
   logic                  na_ff, nb_ff;
   logic [DATA_WIDTH:0]   trial_in;
   logic [DATA_WIDTH:0]   diff_in;
   logic [DATA_WIDTH-1:0] rem_in, quo_in;

   always_comb begin
      trial_in = {in_rem, in_dvd[DATA_WIDTH-1-BIT_INDEX]};
      diff_in  = trial_in - {1'b0, in_dvs};
      quo_in   = in_quo;
      if (!diff_in[DATA_WIDTH]) begin
         rem_in = diff_in[DATA_WIDTH-1:0];
         quo_in[DATA_WIDTH-1-BIT_INDEX] = 1'b1;
      end else begin
         rem_in = trial_in[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         div_ff <= in_div;
         op_ff  <= in_op;
         a_ff   <= in_a;
         b_ff   <= in_b;
         na_ff  <= in_na;
         nb_ff  <= in_nb;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvd_ff <= in_dvd;
         dvs_ff <= in_dvs;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_op    = op_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_na    = na_ff;
   assign out_nb    = nb_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_dvd   = dvd_ff;
   assign out_dvs   = dvs_ff;
endmodule

// File: sv/integer_alu_with_divide.sv
// A word passes the front stage, a chain of DATA_WIDTH cells and the output register.
// One word per cycle while the pipe advances; the divider is DATA_WIDTH restoring
// cells, one quotient bit per cell, and the multiply is registered in the front stage.
// The whole pipe advances when the output register is empty or being taken.
// Reset is synchronous and clears only the valid bits of the pipe.
module integer_alu_with_divide #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [iad_pkg::OP_WIDTH-1:0] req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_result,
   output logic signed [DATA_WIDTH-1:0] rsp_second_result,
   output logic                         rsp_flag,
   output logic                         rsp_divide_error
);
   import iad_pkg::*;

   logic                  adv;
   logic                  s0_valid_ff;
   logic [4:0]            s0_op_ff;
   logic [DATA_WIDTH-1:0] s0_a_ff, s0_b_ff, s0_res_ff;
   logic                  s0_flag_ff, s0_div_ff;
   logic [DATA_WIDTH-1:0] s0_res_in;
   logic                  s0_flag_in, s0_div_in;
   logic [DATA_WIDTH-1:0] ma_in, mb_in;

   logic                  c_valid [DATA_WIDTH+1];
   logic                  c_div   [DATA_WIDTH+1];
   logic [4:0]            c_op    [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_a     [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_b     [DATA_WIDTH+1];
   logic                  c_na    [DATA_WIDTH+1];
   logic                  c_nb    [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_rem   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_quo   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_dvd   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] c_dvs   [DATA_WIDTH+1];

   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] out_res_ff, out_res2_ff, out_res_in, out_res2_in;
   logic                  out_flag_ff, out_derr_ff, out_derr_in;
   logic [DATA_WIDTH-1:0] q_in, r_in, m_in;
   logic                  bzero;

   assign adv       = !out_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Front stage: everything but the divide finishes here.
   always_comb begin
      logic [DATA_WIDTH-1:0] cnt;
      logic [DATA_WIDTH-1:0] sh;
      logic [DATA_WIDTH-1:0] asr;
      s0_res_in  = '0;
      s0_flag_in = 1'b0;
      s0_div_in  = 1'b0;
      cnt = '0;
      sh  = '0;
      asr = '0;
      case (req_operation)
         OP_LT:     s0_flag_in = req_operand_a < req_operand_b;
         OP_ODD:    s0_flag_in = req_operand_a[0];
         OP_EVEN:   s0_flag_in = !req_operand_a[0];
         OP_ZERO:   s0_flag_in = req_operand_a == '0;
         OP_POS:    s0_flag_in = !req_operand_a[DATA_WIDTH-1] && req_operand_a != '0;
         OP_NEG:    s0_flag_in = req_operand_a[DATA_WIDTH-1];
         OP_ABS:    s0_res_in = req_operand_a[DATA_WIDTH-1] ? -req_operand_a : req_operand_a;
         OP_NEGATE: s0_res_in = -req_operand_a;
         OP_ADD:    s0_res_in = req_operand_a + req_operand_b;
         OP_SUB:    s0_res_in = req_operand_a - req_operand_b;
         OP_MUL:    s0_res_in = req_operand_a * req_operand_b;
         OP_QUOT, OP_REM, OP_MOD, OP_TRUNCDIV: s0_div_in = 1'b1;
         OP_ASH: begin
            if (!req_operand_b[DATA_WIDTH-1]) begin
               cnt = req_operand_b;
               s0_res_in = (cnt >= DATA_WIDTH) ? '0 : (req_operand_a << cnt);
            end else begin
               cnt = -req_operand_b;
               sh  = {DATA_WIDTH{req_operand_a[DATA_WIDTH-1]}};
               asr = req_operand_a >>> cnt;
               s0_res_in = (cnt >= DATA_WIDTH) ? sh : asr;
            end
         end
         OP_NOT:    s0_res_in = ~req_operand_a;
         OP_AND:    s0_res_in = req_operand_a & req_operand_b;
         OP_OR:     s0_res_in = req_operand_a | req_operand_b;
         OP_XOR:    s0_res_in = req_operand_a ^ req_operand_b;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
      if (adv) begin
         s0_op_ff   <= req_operation;
         s0_a_ff    <= req_operand_a;
         s0_b_ff    <= req_operand_b;
         s0_res_ff  <= s0_res_in;
         s0_flag_ff <= s0_flag_in;
         s0_div_ff  <= s0_div_in;
      end
   end

   assign ma_in = s0_a_ff[DATA_WIDTH-1] ? -s0_a_ff : s0_a_ff;
   assign mb_in = s0_b_ff[DATA_WIDTH-1] ? -s0_b_ff : s0_b_ff;

   // Non-divide words ride the chain with their result in the operand-a lane.
   assign c_valid[0] = s0_valid_ff;
   assign c_div[0]   = s0_div_ff;
   assign c_op[0]    = s0_op_ff;
   assign c_a[0]     = {s0_res_ff[DATA_WIDTH-1:1], s0_flag_ff | s0_res_ff[0]};
   assign c_b[0]     = s0_b_ff;
   assign c_na[0]    = s0_a_ff[DATA_WIDTH-1];
   assign c_nb[0]    = s0_b_ff[DATA_WIDTH-1];
   assign c_rem[0]   = '0;
   assign c_quo[0]   = '0;
   assign c_dvd[0]   = ma_in;
   assign c_dvs[0]   = mb_in;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      iad_cell #(.DATA_WIDTH(DATA_WIDTH), .BIT_INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c_valid[i]),
         .in_div    (c_div[i]),
         .in_op     (c_op[i]),
         .in_a      (c_a[i]),
         .in_b      (c_b[i]),
         .in_na     (c_na[i]),
         .in_nb     (c_nb[i]),
         .in_rem    (c_rem[i]),
         .in_quo    (c_quo[i]),
         .in_dvd    (c_dvd[i]),
         .in_dvs    (c_dvs[i]),
         .out_valid (c_valid[i+1]),
         .out_div   (c_div[i+1]),
         .out_op    (c_op[i+1]),
         .out_a     (c_a[i+1]),
         .out_b     (c_b[i+1]),
         .out_na    (c_na[i+1]),
         .out_nb    (c_nb[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_quo   (c_quo[i+1]),
         .out_dvd   (c_dvd[i+1]),
         .out_dvs   (c_dvs[i+1])
      );
   end

   // The flag rides in bit zero of the front result; predicates leave the rest zero.
   logic [DATA_WIDTH-1:0] fin_a;
   logic [4:0]            fin_op;
   logic                  fin_flag;
   assign fin_a  = c_a[DATA_WIDTH];
   assign fin_op = c_op[DATA_WIDTH];
   assign fin_flag = (fin_op <= OP_NEG) && fin_a[0];
   assign bzero  = c_dvs[DATA_WIDTH] == '0;

   always_comb begin
      q_in = (c_na[DATA_WIDTH] != c_nb[DATA_WIDTH]) ? -c_quo[DATA_WIDTH] : c_quo[DATA_WIDTH];
      r_in = c_na[DATA_WIDTH] ? -c_rem[DATA_WIDTH] : c_rem[DATA_WIDTH];
      m_in = (r_in != '0 && r_in[DATA_WIDTH-1] != c_nb[DATA_WIDTH])
             ? r_in + c_b[DATA_WIDTH] : r_in;
      out_res2_in = '0;
      out_derr_in = 1'b0;
      if (c_div[DATA_WIDTH]) begin
         if (bzero) begin
            out_res_in  = '0;
            out_derr_in = 1'b1;
         end else begin
            case (fin_op)
               OP_QUOT: out_res_in = q_in;
               OP_REM:  out_res_in = r_in;
               OP_MOD:  out_res_in = m_in;
               default: begin
                  out_res_in  = q_in;
                  out_res2_in = r_in;
               end
            endcase
         end
      end else if (fin_op <= OP_NEG) begin
         out_res_in = '0;
      end else begin
         out_res_in = fin_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= c_valid[DATA_WIDTH];
      end
      if (adv) begin
         out_res_ff  <= out_res_in;
         out_res2_ff <= out_res2_in;
         out_flag_ff <= fin_flag;
         out_derr_ff <= out_derr_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result        = out_res_ff;
   assign rsp_second_result = out_res2_ff;
   assign rsp_flag          = out_flag_ff;
   assign rsp_divide_error  = out_derr_ff;
endmodule

// File: sv/iad_checker.sv
module iad_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_result,
   input logic [DATA_WIDTH-1:0] rsp_second_result,
   input logic                  rsp_flag,
   input logic                  rsp_divide_error
);
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("stall without held word");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("response changed while stalled");
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag |-> rsp_result == '0 && !rsp_divide_error)
      else $error("flag with nonzero result");
   a_derr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_result == '0 && rsp_second_result == '0)
      else $error("divide error with nonzero result");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("valid after reset");
endmodule

bind integer_alu_with_divide iad_checker #(.DATA_WIDTH(DATA_WIDTH)) u_iad_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_result        (rsp_result),
   .rsp_second_result (rsp_second_result),
   .rsp_flag          (rsp_flag),
   .rsp_divide_error  (rsp_divide_error)
);
